// ===== hw/rtl/dq_pkg.sv =====
// package for the double ended queue: beat types, request modes, status codes
// and the per-cell control group; used by every file under hw/rtl
package dq_pkg;

   localparam int DEPTH_DEFAULT = 8;
   localparam int WORD_WIDTH    = 32;

   localparam logic [1:0] MODE_PUSH_FRONT = 2'd0;
   localparam logic [1:0] MODE_PUSH_BACK  = 2'd1;
   localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
   localparam logic [1:0] MODE_POP_BACK   = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]                   mode;
      logic signed [WORD_WIDTH-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] pop_value;
      logic [1:0]                   status;
   } rsp_type;

   // broadcast to every cell, at most one bit set
   typedef struct packed {
      logic push_front;
      logic push_back;
      logic pop_front;
      logic pop_back;
   } cell_ctl_type;

endpackage

// ===== hw/rtl/dq_cell.sv =====
// one storage cell of the queue chain: a word and its occupied flag
// depends on dq_pkg for the control group and word width
module dq_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dq_pkg::cell_ctl_type                 ctl,
   input  logic                                 left_valid,
   input  logic signed [dq_pkg::WORD_WIDTH-1:0] left_data,
   input  logic                                 right_valid,
   input  logic signed [dq_pkg::WORD_WIDTH-1:0] right_data,
   input  logic signed [dq_pkg::WORD_WIDTH-1:0] push_data,
   output logic                                 cell_valid,
   output logic signed [dq_pkg::WORD_WIDTH-1:0] cell_data,
   output logic signed [dq_pkg::WORD_WIDTH-1:0] tail_tap
);

   logic                                 valid_ff, valid_in;
   logic signed [dq_pkg::WORD_WIDTH-1:0] data_ff, data_in;
   logic                                 is_tail;

   // last occupied cell of the chain
   assign is_tail = valid_ff & ~right_valid;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctl.push_front) begin
         valid_in = left_valid;
         data_in  = left_data;
      end else if (ctl.pop_front) begin
         valid_in = right_valid;
         data_in  = right_data;
      end else if (ctl.push_back) begin
         // first empty cell behind an occupied one takes the word
         if (!valid_ff && left_valid) begin
            valid_in = 1'b1;
            data_in  = push_data;
         end
      end else if (ctl.pop_back) begin
         if (is_tail) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign cell_valid = valid_ff;
   assign cell_data  = data_ff;
   assign tail_tap   = is_tail ? data_ff : '0;

endmodule

// ===== hw/rtl/double_ended_queue.sv =====
// double ended queue of DEPTH words held left-justified in a chain of cells
// the result beat is registered and appears in the cycle after the request beat is accepted
// throughput: one request per cycle; only a stalled, full result register holds requests
// reset: synchronous, empties every cell and drops any pending result beat
// depends on dq_pkg and dq_cell
module double_ended_queue #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  dq_pkg::req_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output dq_pkg::rsp_type rsp_payload
);

   logic                                 cell_valid [DEPTH];
   logic signed [dq_pkg::WORD_WIDTH-1:0] cell_data  [DEPTH];
   logic signed [dq_pkg::WORD_WIDTH-1:0] tail_tap   [DEPTH];
   logic signed [dq_pkg::WORD_WIDTH-1:0] tail_word;

   dq_pkg::cell_ctl_type ctl;
   logic                 accept, is_push, full, empty;
   logic [1:0]           status;
   logic signed [dq_pkg::WORD_WIDTH-1:0] pop_word;

   logic            rsp_valid_ff, rsp_valid_in;
   dq_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign is_push   = (req_payload.mode == dq_pkg::MODE_PUSH_FRONT) ||
                      (req_payload.mode == dq_pkg::MODE_PUSH_BACK);
   assign full      = cell_valid[DEPTH-1];
   assign empty     = ~cell_valid[0];

   always_comb begin
      status = dq_pkg::STATUS_OK;
      if (is_push && full) begin
         status = dq_pkg::STATUS_FULL;
      end else if (!is_push && empty) begin
         status = dq_pkg::STATUS_EMPTY;
      end
   end

   always_comb begin
      ctl = '0;
      if (accept && status == dq_pkg::STATUS_OK) begin
         case (req_payload.mode)
            dq_pkg::MODE_PUSH_FRONT: ctl.push_front = 1'b1;
            dq_pkg::MODE_PUSH_BACK:  ctl.push_back  = 1'b1;
            dq_pkg::MODE_POP_FRONT:  ctl.pop_front  = 1'b1;
            dq_pkg::MODE_POP_BACK:   ctl.pop_back   = 1'b1;
            default:                 ctl = '0;
         endcase
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                                 left_valid, right_valid;
      logic signed [dq_pkg::WORD_WIDTH-1:0] left_data, right_data;

      if (i == 0) begin : g_head
         // the incoming word enters from the left end
         assign left_valid = 1'b1;
         assign left_data  = req_payload.push_value;
      end else begin : g_body
         assign left_valid = cell_valid[i-1];
         assign left_data  = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_end
         assign right_valid = 1'b0;
         assign right_data  = '0;
      end else begin : g_mid
         assign right_valid = cell_valid[i+1];
         assign right_data  = cell_data[i+1];
      end

      dq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_valid  (left_valid),
         .left_data   (left_data),
         .right_valid (right_valid),
         .right_data  (right_data),
         .push_data   (req_payload.push_value),
         .cell_valid  (cell_valid[i]),
         .cell_data   (cell_data[i]),
         .tail_tap    (tail_tap[i])
      );
   end

   // only the tail cell drives a non-zero tap
   always_comb begin
      tail_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_word = tail_word | tail_tap[i];
      end
   end

   always_comb begin
      pop_word = '0;
      if (ctl.pop_front) begin
         pop_word = cell_data[0];
      end else if (ctl.pop_back) begin
         pop_word = tail_word;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (accept) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.pop_value = pop_word;
         rsp_payload_in.status    = status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
